### hw/rtl/awvn_pkg.sv
// shared constants and codes for the area-weighted vertex normal block
package awvn_pkg;

    // default sizes
    localparam int MAX_VERTICES_DEF = 1024;
    localparam int COORD_BITS_DEF   = 16;
    localparam int SUM_BITS_DEF     = 48;

    // payload widths
    localparam int FIELD_W = 16;
    localparam int COUNT_W = 11;
    localparam int IN_W    = 7 * FIELD_W;
    localparam int OUT_W   = 3 * FIELD_W;

    // request kinds carried on s_tuser
    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_TRI  = 2'd1;
    localparam logic [1:0] FUNC_READ = 2'd2;

    // result status carried on m_tuser
    localparam logic [1:0] STATUS_NORM  = 2'd0;
    localparam logic [1:0] STATUS_UP    = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    // largest Q1.15 value
    localparam logic [FIELD_W-1:0] Q_ONE = 16'h7FFF;

endpackage

### hw/rtl/awvn_ram.sv
// generic single-write, single-read memory with registered read data
module awvn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/area_weighted_vertex_normals.sv
// top level of the area-weighted vertex normal generator
//
// Requests enter on the s_ group: s_tuser selects load (store a position and
// clear its sums), triangle (add (b-a)x(c-a) into the three corner sums) or
// read (return the unit normal of one vertex). Read results leave on the m_
// group, status on m_tuser. vertex_count is written on the cfg_ channel;
// the user must write it only while the block is idle; no check enforces it.
// After reset the sum memory is swept to zero, one entry a cycle; s_tready
// stays low meanwhile. One request is worked on at a time, under a sequencer
// sharing one 33x33 multiplier and one saturating adder set, with separate
// shift/subtract logic for the root and for the divisions:
//   load: written as it is accepted; triangle: three position reads, six
//   products, three read-modify-writes; read: normalizing shift of one bit
//   per cycle (up to 30 bits), sum of squares, root, and three divisions.
// Out-of-range reads go straight to the output step. A result waits in the
// output register while the receiver stalls; loads and triangles keep being
// taken meanwhile, and a read only holds in its last step until the register
// is free.
module area_weighted_vertex_normals
    import awvn_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int COORD_BITS   = COORD_BITS_DEF,
    parameter int SUM_BITS     = SUM_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    // vertex_index, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c
    input  logic [IN_W-1:0]    s_tdata,
    // func
    input  logic [1:0]         s_tuser,
    output logic               m_tvalid,
    input  logic               m_tready,
    // normal_x, normal_y, normal_z
    output logic [OUT_W-1:0]   m_tdata,
    // status
    output logic [1:0]         m_tuser,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [COUNT_W-1:0] cfg_data
);

    localparam int AW  = $clog2(MAX_VERTICES);
    localparam int PW  = 3 * COORD_BITS;
    localparam int SW3 = 3 * SUM_BITS;
    localparam int EW  = COORD_BITS + 1;
    localparam int NW  = 2 * COORD_BITS + 3;
    localparam int CW  = FIELD_W + 1;
    localparam int XW  = 72;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_PRD, S_PCAP, S_MUL, S_SRD, S_SADD,
        S_RRD, S_RCAP, S_NORM, S_SQ, S_SQRT, S_DINIT, S_DSTEP, S_OUT
    } state_t;

    // saturating accumulate of one component
    function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] acc,
                                                    input logic signed [NW-1:0] n);
        logic signed [XW-1:0] t;
        logic signed [XW-1:0] smax;
        logic signed [XW-1:0] smin;
        logic [SUM_BITS-1:0]  r;
        t    = XW'(signed'(acc)) + XW'(n);
        smax = (XW'(1) <<< (SUM_BITS - 1)) - XW'(1);
        smin = -smax - XW'(1);
        if (t > smax)
        begin
            r = smax[SUM_BITS-1:0];
        end
        else if (t < smin)
        begin
            r = smin[SUM_BITS-1:0];
        end
        else
        begin
            r = t[SUM_BITS-1:0];
        end
        return r;
    endfunction

    // low COORD_BITS of a position field as a signed coordinate
    function automatic logic signed [COORD_BITS-1:0] coord(input logic [FIELD_W-1:0] f);
        logic [23:0] raw;
        raw = {8'd0, f};
        return signed'(raw[COORD_BITS-1:0]);
    endfunction

    // control registers
    state_t              state_reg, state_next;
    logic [AW-1:0]       clr_reg, clr_next;
    logic [2:0]          k_reg, k_next;
    logic [4:0]          cnt_reg, cnt_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [COUNT_W-1:0]  vcount_reg, vcount_next;

    // payload registers
    logic [FIELD_W-1:0]          vi_reg, vi_next;
    logic [FIELD_W-1:0]          corner_reg [3];
    logic [FIELD_W-1:0]          corner_next [3];
    logic signed [COORD_BITS-1:0] p_reg [3][3];
    logic signed [COORD_BITS-1:0] p_next [3][3];
    logic signed [NW-1:0]        n_reg [3];
    logic signed [NW-1:0]        n_next [3];
    logic [SUM_BITS-1:0]         m_reg [3];
    logic [SUM_BITS-1:0]         m_next [3];
    logic [2:0]                  neg_reg, neg_next;
    logic [FIELD_W-1:0]          qo_reg [3];
    logic [FIELD_W-1:0]          qo_next [3];
    logic [1:0]                  status_reg, status_next;
    logic [63:0]                 sq_reg, sq_next;
    logic [63:0]                 res_reg, res_next;
    logic [63:0]                 bit_reg, bit_next;
    logic [32:0]                 r_reg, r_next;
    logic [47:0]                 rem_reg, rem_next;
    logic [48:0]                 d_reg, d_next;
    logic [16:0]                 q_reg, q_next;
    logic signed [65:0]          mul_p_reg;
    logic [OUT_W-1:0]            out_data_reg, out_data_next;
    logic [1:0]                  out_user_reg, out_user_next;

    // memory ports
    logic              pos_we;
    logic [AW-1:0]     pos_waddr;
    logic [PW-1:0]     pos_wdata;
    logic [AW-1:0]     pos_raddr;
    logic [PW-1:0]     pos_rdata;
    logic              sum_we;
    logic [AW-1:0]     sum_waddr;
    logic [SW3-1:0]    sum_wdata;
    logic [AW-1:0]     sum_raddr;
    logic [SW3-1:0]    sum_rdata;

    // request fields
    logic [1:0]         in_func;
    logic [FIELD_W-1:0] in_vi;
    logic [FIELD_W-1:0] in_pos [3];
    logic [FIELD_W-1:0] in_cor [3];
    logic               accept;
    logic [CW-1:0]      live_cnt;
    logic               vi_ok;
    logic               tri_ok;

    // shared multiplier operands and helpers
    logic signed [32:0]   mul_a;
    logic signed [32:0]   mul_b;
    logic signed [EW-1:0] e1 [3];
    logic signed [EW-1:0] e2 [3];
    logic signed [NW-1:0] prod;
    logic [SUM_BITS-1:0]  top;
    logic [64:0]          sqrt_t;
    logic [16:0]          q_step;
    logic [16:0]          q_sat;
    logic [1:0]           kk;
    logic [1:0]           pk;

    assign in_func   = s_tuser;
    assign in_vi     = s_tdata[15:0];
    assign in_pos[0] = s_tdata[31:16];
    assign in_pos[1] = s_tdata[47:32];
    assign in_pos[2] = s_tdata[63:48];
    assign in_cor[0] = s_tdata[79:64];
    assign in_cor[1] = s_tdata[95:80];
    assign in_cor[2] = s_tdata[111:96];

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_user_reg;

    // live vertex count and index checks
    assign live_cnt = (CW'(vcount_reg) > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES)
                                                            : CW'(vcount_reg);
    assign vi_ok  = CW'(in_vi) < live_cnt;
    assign tri_ok = (CW'(in_cor[0]) < live_cnt) && (CW'(in_cor[1]) < live_cnt)
                 && (CW'(in_cor[2]) < live_cnt);

    // triangle edges
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = EW'(p_reg[1][i]) - EW'(p_reg[0][i]);
            e2[i] = EW'(p_reg[2][i]) - EW'(p_reg[0][i]);
        end
    end

    assign kk   = k_reg[1:0];
    assign pk   = 2'((k_reg - 3'd1) >> 1);
    assign prod = signed'(mul_p_reg[NW-1:0]);

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_MUL)
        begin
            case (k_reg)
                3'd0:
                begin
                    mul_a = 33'(e1[1]);
                    mul_b = 33'(e2[2]);
                end
                3'd1:
                begin
                    mul_a = 33'(e1[2]);
                    mul_b = 33'(e2[1]);
                end
                3'd2:
                begin
                    mul_a = 33'(e1[2]);
                    mul_b = 33'(e2[0]);
                end
                3'd3:
                begin
                    mul_a = 33'(e1[0]);
                    mul_b = 33'(e2[2]);
                end
                3'd4:
                begin
                    mul_a = 33'(e1[0]);
                    mul_b = 33'(e2[1]);
                end
                3'd5:
                begin
                    mul_a = 33'(e1[1]);
                    mul_b = 33'(e2[0]);
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
        else if (state_reg == S_SQ && k_reg < 3'd3)
        begin
            mul_a = signed'(33'(m_reg[kk][30:0]));
            mul_b = signed'(33'(m_reg[kk][30:0]));
        end
    end

    // largest magnitude, root step and division step
    always_comb
    begin
        top = m_reg[0];
        if (m_reg[1] > top)
        begin
            top = m_reg[1];
        end
        if (m_reg[2] > top)
        begin
            top = m_reg[2];
        end
    end

    assign sqrt_t = {1'b0, res_reg} + {1'b0, bit_reg};
    assign q_step = {q_reg[15:0], ({1'b0, rem_reg} >= d_reg)};
    assign q_sat  = (q_step > 17'(Q_ONE)) ? 17'(Q_ONE) : q_step;

    // memory address and data selection
    always_comb
    begin
        pos_we    = accept && (in_func == FUNC_LOAD) && vi_ok;
        pos_waddr = in_vi[AW-1:0];
        pos_wdata = {coord(in_pos[2]), coord(in_pos[1]), coord(in_pos[0])};
        pos_raddr = corner_reg[kk][AW-1:0];
        sum_raddr = (state_reg == S_RRD) ? vi_reg[AW-1:0] : corner_reg[kk][AW-1:0];
        sum_we    = 1'b0;
        sum_waddr = clr_reg;
        sum_wdata = '0;
        if (state_reg == S_CLEAR)
        begin
            sum_we = 1'b1;
        end
        else if (pos_we)
        begin
            sum_we    = 1'b1;
            sum_waddr = in_vi[AW-1:0];
        end
        else if (state_reg == S_SADD)
        begin
            sum_we    = 1'b1;
            sum_waddr = corner_reg[kk][AW-1:0];
            sum_wdata = {sat_add(sum_rdata[3*SUM_BITS-1:2*SUM_BITS], n_reg[2]),
                         sat_add(sum_rdata[2*SUM_BITS-1:SUM_BITS], n_reg[1]),
                         sat_add(sum_rdata[SUM_BITS-1:0], n_reg[0])};
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        k_next        = k_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        vcount_next   = vcount_reg;
        vi_next       = vi_reg;
        corner_next   = corner_reg;
        p_next        = p_reg;
        n_next        = n_reg;
        m_next        = m_reg;
        neg_next      = neg_reg;
        qo_next       = qo_reg;
        status_next   = status_reg;
        sq_next       = sq_reg;
        res_next      = res_reg;
        bit_next      = bit_reg;
        r_next        = r_reg;
        rem_next      = rem_reg;
        d_next        = d_reg;
        q_next        = q_reg;
        out_data_next = out_data_reg;
        out_user_next = out_user_reg;

        if (cfg_valid)
        begin
            vcount_next = cfg_data;
        end
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(MAX_VERTICES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    vi_next     = in_vi;
                    corner_next = in_cor;
                    k_next      = 3'd0;
                    if (in_func == FUNC_TRI && tri_ok)
                    begin
                        state_next = S_PRD;
                    end
                    else if (in_func == FUNC_READ && vi_ok)
                    begin
                        state_next = S_RRD;
                    end
                    else if (in_func == FUNC_READ)
                    begin
                        qo_next     = '{default: '0};
                        status_next = STATUS_RANGE;
                        state_next  = S_OUT;
                    end
                end
            end
            S_PRD:
            begin
                state_next = S_PCAP;
            end
            S_PCAP:
            begin
                p_next[kk][0] = signed'(pos_rdata[COORD_BITS-1:0]);
                p_next[kk][1] = signed'(pos_rdata[2*COORD_BITS-1:COORD_BITS]);
                p_next[kk][2] = signed'(pos_rdata[3*COORD_BITS-1:2*COORD_BITS]);
                if (k_reg == 3'd2)
                begin
                    k_next     = 3'd0;
                    n_next     = '{default: '0};
                    state_next = S_MUL;
                end
                else
                begin
                    k_next     = k_reg + 3'd1;
                    state_next = S_PRD;
                end
            end
            S_MUL:
            begin
                // even products add, odd products subtract
                if (k_reg != 3'd0)
                begin
                    if (k_reg[0])
                    begin
                        n_next[pk] = n_reg[pk] + prod;
                    end
                    else
                    begin
                        n_next[pk] = n_reg[pk] - prod;
                    end
                end
                if (k_reg == 3'd6)
                begin
                    k_next     = 3'd0;
                    state_next = S_SRD;
                end
                else
                begin
                    k_next = k_reg + 3'd1;
                end
            end
            S_SRD:
            begin
                state_next = S_SADD;
            end
            S_SADD:
            begin
                if (k_reg == 3'd2)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    k_next     = k_reg + 3'd1;
                    state_next = S_SRD;
                end
            end
            S_RRD:
            begin
                state_next = S_RCAP;
            end
            S_RCAP:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    neg_next[i] = sum_rdata[(i+1)*SUM_BITS-1];
                    m_next[i]   = sum_rdata[(i+1)*SUM_BITS-1]
                                ? (~sum_rdata[i*SUM_BITS +: SUM_BITS] + SUM_BITS'(1))
                                : sum_rdata[i*SUM_BITS +: SUM_BITS];
                end
                if (sum_rdata == '0)
                begin
                    qo_next     = '{'0, Q_ONE, '0};
                    status_next = STATUS_UP;
                    state_next  = S_OUT;
                end
                else
                begin
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                // one bit of shift per cycle toward [2^30, 2^31)
                if (top[SUM_BITS-1:31] != '0)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        m_next[i] = m_reg[i] >> 1;
                    end
                end
                else if (!top[30])
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        m_next[i] = m_reg[i] << 1;
                    end
                end
                else
                begin
                    k_next     = 3'd0;
                    sq_next    = '0;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                if (k_reg != 3'd0)
                begin
                    sq_next = sq_reg + mul_p_reg[63:0];
                end
                if (k_reg == 3'd3)
                begin
                    res_next   = '0;
                    bit_next   = 64'd1 << 62;
                    state_next = S_SQRT;
                end
                else
                begin
                    k_next = k_reg + 3'd1;
                end
            end
            S_SQRT:
            begin
                if ({1'b0, sq_reg} >= sqrt_t)
                begin
                    sq_next  = sq_reg - sqrt_t[63:0];
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    r_next     = res_next[32:0];
                    k_next     = 3'd0;
                    state_next = S_DINIT;
                end
            end
            S_DINIT:
            begin
                rem_next   = 48'({m_reg[kk][30:0], 15'd0}) + 48'(r_reg >> 1);
                d_next     = 49'(r_reg) << 16;
                q_next     = '0;
                cnt_next   = 5'd16;
                state_next = S_DSTEP;
            end
            S_DSTEP:
            begin
                if ({1'b0, rem_reg} >= d_reg)
                begin
                    rem_next = 48'({1'b0, rem_reg} - d_reg);
                end
                d_next   = d_reg >> 1;
                q_next   = q_step;
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    qo_next[kk] = neg_reg[kk] ? (~q_sat[15:0] + 16'd1) : q_sat[15:0];
                    if (k_reg == 3'd2)
                    begin
                        status_next = STATUS_NORM;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        k_next     = k_reg + 3'd1;
                        state_next = S_DINIT;
                    end
                end
            end
            S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    out_data_next = {qo_reg[2], qo_reg[1], qo_reg[0]};
                    out_user_next = status_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            k_reg        <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            vcount_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            k_reg        <= k_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            vcount_reg   <= vcount_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        vi_reg       <= vi_next;
        corner_reg   <= corner_next;
        p_reg        <= p_next;
        n_reg        <= n_next;
        m_reg        <= m_next;
        neg_reg      <= neg_next;
        qo_reg       <= qo_next;
        status_reg   <= status_next;
        sq_reg       <= sq_next;
        res_reg      <= res_next;
        bit_reg      <= bit_next;
        r_reg        <= r_next;
        rem_reg      <= rem_next;
        d_reg        <= d_next;
        q_reg        <= q_next;
        mul_p_reg    <= mul_a * mul_b;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    // vertex positions
    awvn_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_VERTICES)
    ) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    // per-vertex normal sums
    awvn_ram #(
        .WIDTH (SW3),
        .DEPTH (MAX_VERTICES)
    ) u_sum_ram (
        .clk   (clk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    // no request taken during the clearing sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !s_tready)
        else $error("request taken during clear sweep");

    // normalized magnitudes stay in [2^30, 2^31) while squaring
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SQ) |-> (top[SUM_BITS-1:31] == '0) && top[30])
        else $error("normalization out of range");

    // root of a normalized sum is at least 2^30
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DINIT) |-> (r_reg[32:30] != 3'b000))
        else $error("root below divisor range");

    // only defined status codes are presented
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == STATUS_NORM || m_tuser == STATUS_UP
                      || m_tuser == STATUS_RANGE))
        else $error("undefined status on output");

endmodule

### dv/tb_top.sv
// self-checking testbench for the area-weighted vertex normal block
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import awvn_pkg::*;

    localparam int NV       = MAX_VERTICES_DEF;
    localparam int WD_LIMIT = 20000;

    // request kind that the block ignores
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // normal result as seen on the master side
    typedef struct packed {
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
        logic [1:0]  status;
    } normal_t;

    int                 n_errors;

    // mismatch report
    task automatic report_err(string what, longint got, longint want);
        n_errors++;
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    endtask

    // mirror of the block state plus the queue of pending normals
    class normal_scoreboard;
        logic signed [15:0] px [NV];
        logic signed [15:0] py [NV];
        logic signed [15:0] pz [NV];
        logic signed [47:0] sx [NV];
        logic signed [47:0] sy [NV];
        logic signed [47:0] sz [NV];
        bit                 loaded [NV];
        int unsigned        vcount;
        normal_t            pending [$];

        function new();
            for (int i = 0; i < NV; i++)
            begin
                px[i] = 0; py[i] = 0; pz[i] = 0;
                sx[i] = 0; sy[i] = 0; sz[i] = 0;
                loaded[i] = 0;
            end
            vcount = 0;
        endfunction

        function int unsigned live();
            return (vcount > NV) ? NV : vcount;
        endfunction

        function logic signed [47:0] sat48(logic signed [47:0] acc, logic signed [63:0] n);
            logic signed [63:0] t;
            t = 64'(acc) + n;
            if (t > 64'sh7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
            if (t < -64'sh8000_0000_0000) return 48'sh8000_0000_0000;
            return t[47:0];
        endfunction

        function longint unsigned root64(longint unsigned s);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > s) b >>= 2;
            while (b != 0)
            begin
                if (s >= res + b)
                begin
                    s -= res + b;
                    res = (res >> 1) + b;
                end
                else
                    res >>= 1;
                b >>= 2;
            end
            return res;
        endfunction

        // note one accepted request and queue its normal, if any
        function void note_request(logic [1:0] fn, logic [IN_W-1:0] d);
            int unsigned vi, a, b, c;
            logic signed [63:0] e1x, e1y, e1z, e2x, e2y, e2z, nx, ny, nz;
            logic signed [47:0] s [3];
            longint unsigned m [3];
            longint unsigned top, sq, r, v;
            normal_t res;
            vi = d[15:0];
            a = d[79:64]; b = d[95:80]; c = d[111:96];
            case (fn)
                FUNC_LOAD:
                begin
                    if (vi < live())
                    begin
                        px[vi] = d[31:16]; py[vi] = d[47:32]; pz[vi] = d[63:48];
                        sx[vi] = 0; sy[vi] = 0; sz[vi] = 0;
                        loaded[vi] = 1;
                    end
                end
                FUNC_TRI:
                begin
                    if (a < live() && b < live() && c < live())
                    begin
                        e1x = 64'(px[b]) - 64'(px[a]);
                        e1y = 64'(py[b]) - 64'(py[a]);
                        e1z = 64'(pz[b]) - 64'(pz[a]);
                        e2x = 64'(px[c]) - 64'(px[a]);
                        e2y = 64'(py[c]) - 64'(py[a]);
                        e2z = 64'(pz[c]) - 64'(pz[a]);
                        nx = e1y * e2z - e1z * e2y;
                        ny = e1z * e2x - e1x * e2z;
                        nz = e1x * e2y - e1y * e2x;
                        foreach (s[k])
                        begin
                            vi = (k == 0) ? a : (k == 1) ? b : c;
                            sx[vi] = sat48(sx[vi], nx);
                            sy[vi] = sat48(sy[vi], ny);
                            sz[vi] = sat48(sz[vi], nz);
                        end
                    end
                end
                FUNC_READ:
                begin
                    if (vi >= live())
                        res = '{16'd0, 16'd0, 16'd0, STATUS_RANGE};
                    else if (sx[vi] == 0 && sy[vi] == 0 && sz[vi] == 0)
                        res = '{16'd0, Q_ONE, 16'd0, STATUS_UP};
                    else
                    begin
                        s[0] = sx[vi]; s[1] = sy[vi]; s[2] = sz[vi];
                        for (int k = 0; k < 3; k++)
                            m[k] = s[k] < 0 ? longint'(-64'(s[k])) : longint'(64'(s[k]));
                        top = m[0];
                        if (m[1] > top) top = m[1];
                        if (m[2] > top) top = m[2];
                        while (top >= (64'd1 << 31))
                        begin
                            top >>= 1;
                            for (int k = 0; k < 3; k++) m[k] >>= 1;
                        end
                        while (top < (64'd1 << 30))
                        begin
                            top <<= 1;
                            for (int k = 0; k < 3; k++) m[k] <<= 1;
                        end
                        sq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
                        r = root64(sq);
                        res.status = STATUS_NORM;
                        for (int k = 0; k < 3; k++)
                        begin
                            v = (m[k] * 32768 + r / 2) / r;
                            if (v > 32767) v = 32767;
                            if (s[k] < 0) v = -v;
                            if (k == 0) res.nx = v[15:0];
                            else if (k == 1) res.ny = v[15:0];
                            else res.nz = v[15:0];
                        end
                    end
                    pending.push_back(res);
                end
                default: ;
            endcase
        endfunction

        // compare one accepted normal against the oldest expectation
        task check_normal(normal_t got);
            normal_t exp_n;
            if (pending.size() == 0)
            begin
                report_err("normal with nothing pending", 0, 0);
                return;
            end
            exp_n = pending.pop_front();
            if (got.nx !== exp_n.nx) report_err("normal_x", got.nx, exp_n.nx);
            if (got.ny !== exp_n.ny) report_err("normal_y", got.ny, exp_n.ny);
            if (got.nz !== exp_n.nz) report_err("normal_z", got.nz, exp_n.nz);
            if (got.status !== exp_n.status) report_err("status", got.status, exp_n.status);
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata;   // vertex_index, pos_x, pos_y, pos_z, corner_a/b/c
    logic [1:0]         s_tuser;   // func
    logic               m_tvalid;
    logic               m_tready;
    logic [OUT_W-1:0]   m_tdata;   // normal_x, normal_y, normal_z
    logic [1:0]         m_tuser;   // status
    logic               cfg_valid;
    logic               cfg_ready;
    logic [COUNT_W-1:0] cfg_data;

    int                 idle_cycles;
    bit                 stim_done;
    normal_scoreboard   sb;

    area_weighted_vertex_normals i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // register write while idle
    task automatic write_count(int unsigned val);
        s_tvalid  <= 0;
        cfg_valid <= 1;
        cfg_data  <= val[COUNT_W-1:0];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 0;
        sb.vcount = val;
    endtask

    // send one request with a random gap before it
    task automatic send(logic [1:0] fn, logic [15:0] vi, logic [15:0] x, logic [15:0] y,
                        logic [15:0] z, logic [15:0] a, logic [15:0] b, logic [15:0] c);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        if (gap != 0)
        begin
            s_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tuser  <= fn;
        s_tdata  <= {c, b, a, z, y, x, vi};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_request(fn, s_tdata);
    endtask

    // wait until every normal is back, then give loads and triangles time to finish
    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    // random loaded vertex index below the live count
    function automatic logic [15:0] pick(int unsigned n);
        int unsigned i;
        do i = $urandom_range(0, n - 1); while (!sb.loaded[i]);
        return 16'(i);
    endfunction

    // one random phase with a given vertex count
    task automatic random_phase(int unsigned cnt, int items);
        int unsigned n, k;
        logic [15:0] big;
        n = (cnt > NV) ? NV : cnt;
        for (int i = 0; i < items; i++)
        begin
            k = $urandom_range(0, 99);
            big = 16'(n + $urandom_range(0, 3));
            if ($urandom_range(0, 1)) big = 16'($urandom);
            if (k < 25 || !sb.loaded[0])
                send(FUNC_LOAD, (k % 10 == 0) ? big : 16'($urandom_range(0, n - 1)),
                     16'($urandom), 16'($urandom), 16'($urandom), 16'd0, 16'd0, 16'd0);
            else if (k < 65)
                send(FUNC_TRI, 16'($urandom), 16'd0, 16'd0, 16'd0, pick(n),
                     (k % 13 == 0) ? big : pick(n), pick(n));
            else if (k < 95)
                send(FUNC_READ, (k % 12 == 0) ? big : pick(n), 16'($urandom),
                     16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom));
            else
                send(FUNC_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        end
    endtask

    // result side: random stalls and checking
    initial
    begin
        m_tready <= 0;
        @(posedge rst_n);
        forever
        begin
            int stall;
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            if (stall != 0)
            begin
                m_tready <= 0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            sb.check_normal({m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tuser});
        end
    end

    // watchdog on cycles without any handshake
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
                || !rst_n)
                idle_cycles = 0;
            else if (!stim_done)
                idle_cycles++;
            if (idle_cycles >= WD_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        sb = new();
        n_errors = 0;
        stim_done = 0;
        rst_n = 0;
        s_tvalid <= 0; s_tdata <= '0; s_tuser <= FUNC_LOAD;
        cfg_valid <= 0; cfg_data <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: empty mesh, then extremes
        send(FUNC_READ, 0, 0, 0, 0, 0, 0, 0);
        send(FUNC_LOAD, 0, 16'h7FFF, 0, 0, 0, 0, 0);
        drain();
        write_count(2047);
        send(FUNC_LOAD, 0, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0);
        send(FUNC_LOAD, 1, 16'h7FFF, 16'h8000, 16'h8000, 0, 0, 0);
        send(FUNC_LOAD, 2, 16'h8000, 16'h7FFF, 16'h8000, 0, 0, 0);
        send(FUNC_LOAD, 1023, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 0, 0);
        send(FUNC_LOAD, 1024, 1, 1, 1, 0, 0, 0);
        send(FUNC_LOAD, 16'hFFFF, 1, 1, 1, 0, 0, 0);
        send(FUNC_READ, 1, 0, 0, 0, 0, 0, 0);
        send(FUNC_READ, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send(FUNC_TRI, 0, 0, 0, 0, 0, 1, 2);
        send(FUNC_TRI, 0, 0, 0, 0, 0, 1, 1024);
        send(FUNC_TRI, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send(FUNC_TRI, 0, 0, 0, 0, 0, 0, 1);
        send(FUNC_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
             16'hFFFF);
        send(FUNC_READ, 0, 0, 0, 0, 0, 0, 0);
        // pile up large sums on one triangle
        for (int i = 0; i < 300; i++)
            send(FUNC_TRI, 0, 0, 0, 0, 0, 1, 2);
        send(FUNC_READ, 0, 0, 0, 0, 0, 0, 0);
        send(FUNC_TRI, 0, 0, 0, 0, 2, 1, 0);
        send(FUNC_READ, 2, 0, 0, 0, 0, 0, 0);
        send(FUNC_READ, 1023, 0, 0, 0, 0, 0, 0);
        drain();

        // random phases over several counts
        write_count(3);
        random_phase(3, 150);
        drain();
        write_count(1024);
        random_phase(1024, 300);
        drain();
        write_count(16);
        random_phase(16, 280);
        drain();
        write_count(1500);
        random_phase(1024, 150);
        drain();
        write_count(0);
        random_phase(1, 0);
        send(FUNC_READ, 0, 0, 0, 0, 0, 0, 0);
        send(FUNC_TRI, 0, 0, 0, 0, 0, 0, 0);
        drain();
        write_count(5);
        random_phase(5, 150);
        drain();
        stim_done = 1;

        if (n_errors == 0 && sb.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
